@@ src/stip_pkg.sv @@
package stip_pkg;

	localparam int BASE_W  = 6;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 16;
	localparam int DIGIT_W = 5;
	localparam int DVAL_W  = 5;
	localparam int PROD_W  = VALUE_W + BASE_W;
	localparam int CNT_W   = $clog2(BASE_W);

	localparam logic [POS_W-1:0] MAX_STRING_LEN = 16'd65535;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

	localparam logic [VALUE_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] LIMIT_NEG = 32'h8000_0000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_SIGNED,
		PH_ZERO,
		PH_ZEROX,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_MUL,
		SQ_PUSH
	} seq_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_MUL,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		logic               load;
		logic [DVAL_W-1:0]  digit;
		logic [VALUE_W-1:0] mcand;
		logic [BASE_W-1:0]  mult;
	} mac_req_t;

	typedef struct packed {
		logic              busy;
		logic [PROD_W-1:0] prod;
	} mac_sts_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
		logic [DIGIT_W-1:0] d;
		d = NOT_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = DIGIT_W'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF_HEX) begin
			d = DIGIT_W'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = DIGIT_W'(c - CH_UA + 8'd10);
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

endpackage

@@ src/string_to_integer_parser_core.sv @@
// string to 32-bit integer parser, one character per input beat
// input channel: in_valid / in_stall with char_byte and string_start; a beat
//   with string_start high opens a new string and drops any parse in progress
// output channel: out_valid / out_stall with value, end_offset, overflowed and
//   no_digits; at most one result beat per string, at its first terminator or overflow
// config: cfg_we / cfg_wdata write number_base (0 = auto hex, octal, decimal)
// input stall: a space, sign or prefix character causes none; a digit holds the
//   input while the shift-add multiplier walks the 6 base bits, one per cycle,
//   then the overflow check; a terminator holds it until the push state drains
// result path: the beat that ends the number, or the check of an overflowing
//   digit, loads the staging registers, which the push state copies to the output
// stall: the output register holds a finished result while the next input
//   beat is taken; a second result waits in the push state until it drains
// reset: number_base returns to 10, the parser goes idle and waits for a
//   string start, the output register is empty
module string_to_integer_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        string_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic [15:0] end_offset,
	output logic        overflowed,
	output logic        no_digits,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	// configuration
	logic [stip_pkg::BASE_W-1:0]  number_base_q;

	// parse state
	stip_pkg::phase_t             phase_q;
	logic                         neg_q;
	logic [stip_pkg::VALUE_W-1:0] acc_q;
	logic [stip_pkg::BASE_W-1:0]  base_q;
	logic [stip_pkg::POS_W-1:0]   pos_q;
	logic                         seen_q;

	// sequencer
	stip_pkg::seq_t               sq_q;
	stip_pkg::seq_t               sq_n;

	// result staging and output register
	logic [stip_pkg::VALUE_W-1:0] res_value_q;
	logic [stip_pkg::POS_W-1:0]   res_end_q;
	logic                         res_ovf_q;
	logic                         res_nod_q;
	logic                         out_valid_q;
	logic [stip_pkg::VALUE_W-1:0] value_q;
	logic [stip_pkg::POS_W-1:0]   end_offset_q;
	logic                         overflowed_q;
	logic                         no_digits_q;

	// next parse values for an accepted beat
	stip_pkg::phase_t             ph_n;
	logic                         neg_n;
	logic [stip_pkg::VALUE_W-1:0] acc_n;
	logic [stip_pkg::BASE_W-1:0]  base_n;
	logic [stip_pkg::POS_W-1:0]   pos_n;
	logic                         seen_n;
	stip_pkg::act_t               act;
	logic [stip_pkg::DIGIT_W-1:0] dig;
	logic [stip_pkg::VALUE_W-1:0] emit_value;
	logic [stip_pkg::POS_W-1:0]   emit_end;
	logic                         emit_nod;

	logic                         accept;
	logic                         out_free;
	logic                         push_load;
	logic                         mac_done;
	logic [stip_pkg::VALUE_W-1:0] limit;
	logic                         ovf;

	stip_pkg::mac_req_t           mac_req;
	stip_pkg::mac_sts_t           mac_sts;

	stip_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.sts    (mac_sts)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mac_done = (sq_q == stip_pkg::SQ_MUL) && !mac_sts.busy;
	assign limit    = neg_q ? stip_pkg::LIMIT_NEG : stip_pkg::LIMIT_POS;
	// acc*base + d past the limit is the same test as the cutoff pair
	assign ovf      = mac_sts.prod > stip_pkg::PROD_W'(limit);

	// character decode for one accepted beat
	always_comb begin
		stip_pkg::phase_t ph_e;
		logic [7:0]       c_e;
		logic             first;
		logic             step;
		ph_e       = phase_q;
		c_e        = char_byte;
		ph_n       = phase_q;
		neg_n      = neg_q;
		acc_n      = acc_q;
		base_n     = base_q;
		pos_n      = pos_q;
		seen_n     = seen_q;
		act        = stip_pkg::ACT_NONE;
		dig        = stip_pkg::NOT_DIGIT;
		emit_value = '0;
		emit_end   = '0;
		emit_nod   = 1'b0;
		first      = 1'b0;
		step       = 1'b0;

		if (string_start) begin
			ph_e   = stip_pkg::PH_SKIP;
			neg_n  = 1'b0;
			acc_n  = '0;
			base_n = '0;
			pos_n  = '0;
			seen_n = 1'b0;
		end else begin
			if (pos_q < stip_pkg::MAX_STRING_LEN) begin
				pos_n = pos_q + 16'd1;
			end
			// the character at the length limit reads as a nul
			if (pos_n >= stip_pkg::MAX_STRING_LEN) begin
				c_e = stip_pkg::CH_NUL;
			end
		end
		ph_n = ph_e;

		unique case (ph_e)
			stip_pkg::PH_IDLE: begin
				pos_n = pos_q;
			end
			stip_pkg::PH_SKIP: begin
				if (stip_pkg::is_space(c_e)) begin
					ph_n = stip_pkg::PH_SKIP;
				end else if (c_e == stip_pkg::CH_MINUS) begin
					neg_n = 1'b1;
					ph_n  = stip_pkg::PH_SIGNED;
				end else if (c_e == stip_pkg::CH_PLUS) begin
					ph_n = stip_pkg::PH_SIGNED;
				end else begin
					first = 1'b1;
				end
			end
			stip_pkg::PH_SIGNED: begin
				first = 1'b1;
			end
			stip_pkg::PH_ZERO: begin
				if (c_e == stip_pkg::CH_LX || c_e == stip_pkg::CH_UX) begin
					ph_n = stip_pkg::PH_ZEROX;
				end else begin
					ph_n = stip_pkg::PH_DIGITS;
					step = 1'b1;
				end
			end
			stip_pkg::PH_ZEROX: begin
				if (stip_pkg::digit_of(c_e) != stip_pkg::NOT_DIGIT) begin
					base_n = stip_pkg::BASE_HEX;
					acc_n  = '0;
					seen_n = 1'b0;
					ph_n   = stip_pkg::PH_DIGITS;
					step   = 1'b1;
				end else begin
					// bare prefix: the number is the zero before the x
					act      = stip_pkg::ACT_EMIT;
					ph_n     = stip_pkg::PH_IDLE;
					emit_end = pos_n - 16'd1;
				end
			end
			stip_pkg::PH_DIGITS: begin
				step = 1'b1;
			end
			default: begin
				ph_n = stip_pkg::PH_IDLE;
			end
		endcase

		if (first) begin
			if ((number_base_q == stip_pkg::BASE_AUTO || number_base_q == stip_pkg::BASE_HEX)
					&& c_e == stip_pkg::CH_0) begin
				base_n = (number_base_q == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT
						: stip_pkg::BASE_HEX;
				acc_n  = '0;
				seen_n = 1'b1;
				ph_n   = stip_pkg::PH_ZERO;
			end else begin
				base_n = (number_base_q == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC
						: number_base_q;
				ph_n   = stip_pkg::PH_DIGITS;
				step   = 1'b1;
			end
		end

		if (step) begin
			dig = stip_pkg::digit_of(c_e);
			if ({1'b0, dig} >= base_n) begin
				// terminator
				act        = stip_pkg::ACT_EMIT;
				ph_n       = stip_pkg::PH_IDLE;
				emit_value = neg_n ? (32'd0 - acc_n) : acc_n;
				emit_end   = seen_n ? pos_n : '0;
				emit_nod   = !seen_n;
			end else begin
				act = stip_pkg::ACT_MUL;
			end
		end
	end

	// sequencer next state
	always_comb begin
		sq_n = sq_q;
		unique case (sq_q)
			stip_pkg::SQ_IDLE: begin
				if (accept && act == stip_pkg::ACT_MUL) begin
					sq_n = stip_pkg::SQ_MUL;
				end else if (accept && act == stip_pkg::ACT_EMIT) begin
					sq_n = stip_pkg::SQ_PUSH;
				end
			end
			stip_pkg::SQ_MUL: begin
				if (mac_done) begin
					sq_n = ovf ? stip_pkg::SQ_PUSH : stip_pkg::SQ_IDLE;
				end
			end
			stip_pkg::SQ_PUSH: begin
				if (out_free) begin
					sq_n = stip_pkg::SQ_IDLE;
				end
			end
			default: begin
				sq_n = stip_pkg::SQ_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall      = (sq_q != stip_pkg::SQ_IDLE);
		push_load     = (sq_q == stip_pkg::SQ_PUSH) && out_free;
		mac_req.load  = (sq_q == stip_pkg::SQ_IDLE) && accept && (act == stip_pkg::ACT_MUL);
		mac_req.digit = dig[stip_pkg::DVAL_W-1:0];
		mac_req.mcand = acc_n;
		mac_req.mult  = base_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= stip_pkg::BASE_RESET;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q    <= stip_pkg::SQ_IDLE;
			phase_q <= stip_pkg::PH_IDLE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
		end else begin
			sq_q <= sq_n;
			if (accept) begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				base_q  <= base_n;
				pos_q   <= pos_n;
				seen_q  <= seen_n;
			end else if (mac_done) begin
				if (ovf) begin
					phase_q <= stip_pkg::PH_IDLE;
				end else begin
					acc_q  <= mac_sts.prod[stip_pkg::VALUE_W-1:0];
					seen_q <= 1'b1;
				end
			end
		end
	end

	// result staging, loaded by a terminator or an overflowing digit
	always_ff @(posedge clk) begin
		if (accept && act == stip_pkg::ACT_EMIT) begin
			res_value_q <= emit_value;
			res_end_q   <= emit_end;
			res_ovf_q   <= 1'b0;
			res_nod_q   <= emit_nod;
		end else if (mac_done && ovf) begin
			// saturated value equals the sign-dependent limit
			res_value_q <= limit;
			res_end_q   <= '0;
			res_ovf_q   <= 1'b1;
			res_nod_q   <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_load) begin
			value_q      <= res_value_q;
			end_offset_q <= res_end_q;
			overflowed_q <= res_ovf_q;
			no_digits_q  <= res_nod_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign end_offset = end_offset_q;
	assign overflowed = overflowed_q;
	assign no_digits  = no_digits_q;

endmodule

@@ src/stip_mac.sv @@
module stip_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  stip_pkg::mac_req_t  req,
	output stip_pkg::mac_sts_t  sts
);

	logic                          busy_q;
	logic [stip_pkg::CNT_W-1:0]    cnt_q;
	logic [stip_pkg::PROD_W-1:0]   prod_q;
	logic [stip_pkg::PROD_W-1:0]   mcand_q;
	logic [stip_pkg::BASE_W-1:0]   mult_q;

	// one multiplier bit per cycle, lsb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == stip_pkg::CNT_W'(stip_pkg::BASE_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// product starts at the digit so the add of d comes for free
	always_ff @(posedge clk) begin
		if (req.load) begin
			prod_q  <= stip_pkg::PROD_W'(req.digit);
			mcand_q <= stip_pkg::PROD_W'(req.mcand);
			mult_q  <= req.mult;
		end else if (busy_q) begin
			if (mult_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mult_q  <= mult_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.prod = prod_q;

endmodule
